// File: rtl/mss_pkg.sv
// Shared constants and types for the median of sample set unit.
package mss_pkg;

	localparam int MAX_SAMPLES  = 64;
	localparam int SAMPLE_WIDTH = 32;
	localparam int MEDIAN_W     = 32;
	localparam int SET_COUNT_W  = 7;
	localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
	localparam int SHF_W        = CNT_W - 1;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	typedef struct packed {
		logic ins;
		logic shd;
		logic clr;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEEK
	} state_t;

endpackage

// File: rtl/mss_cell.sv
// One cell of the sorted insertion chain.
module mss_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  mss_pkg::cell_ctl_t  ctl,
	input  mss_pkg::sample_t    smp,
	input  mss_pkg::sample_t    prev_val,
	input  logic                prev_vld,
	input  logic                prev_gt,
	input  mss_pkg::sample_t    next_val,
	output mss_pkg::sample_t    val,
	output logic                vld,
	output logic                gt
);

	mss_pkg::sample_t val_q;
	logic             vld_q;

	assign val = val_q;
	assign vld = vld_q;
	assign gt  = vld_q && (val_q > smp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clr) begin
			vld_q <= 1'b0;
		end else if (ctl.ins) begin
			vld_q <= vld_q | prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || !vld_q) begin
				val_q <= smp;
			end
		end else if (ctl.shd) begin
			val_q <= next_val;
		end
	end

endmodule

// File: rtl/median_of_sample_set_unit.sv
// Top level: sorted insertion chain with median readout.
//
// channel | handshake                        | payload
// input   | start, busy (accept: start&!busy)| sample, last_sample
// result  | result_valid (one-cycle strobe)  | median_value, set_count, overflow
//
// A sample that does not end a set is taken every cycle: the chain of cells
// inserts it in the cycle that it is taken. On the last sample of a set the chain shifts down
// (n-1)/2 times to bring the middle elements to its head; the block is busy
// while it shifts and captures, and the result strobes in the cycle after the capture.
// Reset clears the sample count, the drop flag and all cell valid bits.
// The receiver cannot stall; each result is shown for one cycle only.
module median_of_sample_set_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [mss_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                 last_sample,
	output logic                                 result_valid,
	output logic signed [mss_pkg::MEDIAN_W-1:0]  median_value,
	output logic        [mss_pkg::SET_COUNT_W-1:0] set_count,
	output logic                                 overflow
);

	localparam int N = mss_pkg::MAX_SAMPLES;

	mss_pkg::state_t    state_q, state_d;
	logic [mss_pkg::CNT_W-1:0] kept_q, kept_d;
	logic [mss_pkg::SHF_W-1:0] shf_q;
	logic               drop_q;
	logic               accept, full, cap;
	mss_pkg::cell_ctl_t ctl;

	mss_pkg::sample_t   cell_val [N];
	logic               cell_vld [N];
	logic               cell_gt  [N];

	logic signed [mss_pkg::SAMPLE_WIDTH:0] pair_sum;
	mss_pkg::sample_t   med_d;

	logic signed [mss_pkg::MEDIAN_W-1:0]     median_q;
	logic        [mss_pkg::SET_COUNT_W-1:0]  count_q;
	logic                                    ovf_q;
	logic                                    rv_q;

	assign accept = start && !busy;
	assign full   = (kept_q == mss_pkg::CNT_W'(N));
	assign kept_d = kept_q + mss_pkg::CNT_W'(accept && !full);

	for (genvar i = 0; i < N; i++) begin : g_cell
		mss_pkg::sample_t pv, nv;
		logic             pvld, pgt;
		if (i == 0) begin : g_head
			assign pv   = '0;
			assign pvld = 1'b1;
			assign pgt  = 1'b0;
		end else begin : g_body
			assign pv   = cell_val[i-1];
			assign pvld = cell_vld[i-1];
			assign pgt  = cell_gt[i-1];
		end
		if (i == N - 1) begin : g_tail
			assign nv = cell_val[i];
		end else begin : g_mid
			assign nv = cell_val[i+1];
		end
		mss_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.smp      (sample),
			.prev_val (pv),
			.prev_vld (pvld),
			.prev_gt  (pgt),
			.next_val (nv),
			.val      (cell_val[i]),
			.vld      (cell_vld[i]),
			.gt       (cell_gt[i])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mss_pkg::ST_IDLE: begin
				if (accept && last_sample) begin
					state_d = mss_pkg::ST_SEEK;
				end
			end
			mss_pkg::ST_SEEK: begin
				if (shf_q == '0) begin
					state_d = mss_pkg::ST_IDLE;
				end
			end
			default: state_d = mss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = 1'b0;
		cap     = 1'b0;
		ctl.ins = 1'b0;
		ctl.shd = 1'b0;
		ctl.clr = 1'b0;
		case (state_q)
			mss_pkg::ST_IDLE: begin
				ctl.ins = start && !full;
			end
			mss_pkg::ST_SEEK: begin
				busy    = 1'b1;
				cap     = (shf_q == '0);
				ctl.shd = (shf_q != '0);
				ctl.clr = (shf_q == '0);
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign pair_sum = {cell_val[0][mss_pkg::SAMPLE_WIDTH-1], cell_val[0]}
		+ {cell_val[1][mss_pkg::SAMPLE_WIDTH-1], cell_val[1]};
	assign med_d = kept_q[0] ? cell_val[0]
		: mss_pkg::SAMPLE_WIDTH'(pair_sum >>> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mss_pkg::ST_IDLE;
			kept_q  <= '0;
			drop_q  <= 1'b0;
			shf_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_q    <= cap;
			if (cap) begin
				kept_q <= '0;
				drop_q <= 1'b0;
			end else if (accept) begin
				kept_q <= kept_d;
				if (full) begin
					drop_q <= 1'b1;
				end
				if (last_sample) begin
					shf_q <= mss_pkg::SHF_W'((kept_d - 1'b1) >> 1);
				end
			end else if (ctl.shd) begin
				shf_q <= shf_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			median_q <= mss_pkg::MEDIAN_W'(med_d);
			count_q  <= mss_pkg::SET_COUNT_W'(kept_q);
			ovf_q    <= drop_q;
		end
	end

	assign result_valid = rv_q;
	assign median_value = median_q;
	assign set_count    = count_q;
	assign overflow     = ovf_q;

endmodule

// File: rtl/mss_checker.sv
// Port-level checks for the median of sample set unit, bound to the top level.
module mss_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    start,
	input logic                                    busy,
	input logic                                    last_sample,
	input logic                                    result_valid,
	input logic [mss_pkg::SET_COUNT_W-1:0]         set_count
);

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_sample |=> busy)
		else $error("no busy after last item");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && last_sample))
		else $error("busy without a last item");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result while busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (set_count >= 7'd1) && (set_count <= 7'(mss_pkg::MAX_SAMPLES)))
		else $error("set count out of range");

endmodule

bind median_of_sample_set_unit mss_checker u_mss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_sample  (last_sample),
	.result_valid (result_valid),
	.set_count    (set_count)
);

// File: tb/median_checker.sv
// Checker for the median unit: predicts each set's median and compares the results.
module median_checker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic                                    busy,
	input  logic signed [mss_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                    last_sample,
	input  logic                                    result_valid,
	input  logic signed [mss_pkg::MEDIAN_W-1:0]     median_value,
	input  logic        [mss_pkg::SET_COUNT_W-1:0]  set_count,
	input  logic                                    overflow,
	output int                                      fails,
	output int                                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import mss_pkg::*;

	typedef struct {
		logic signed [MEDIAN_W-1:0] median;
		logic [SET_COUNT_W-1:0]     count;
		logic                       ovf;
	} median_result_t;

	sample_t        kept_q[$];
	logic           dropped;
	median_result_t median_results_q[$];

	initial begin
		fails   = 0;
		dropped = 1'b0;
	end

	assign pending = median_results_q.size();

	function automatic void keep_sample(input sample_t s);
		int pos;
		pos = kept_q.size();
		for (int i = 0; i < kept_q.size(); i++) begin
			if (kept_q[i] > s) begin
				pos = i;
				break;
			end
		end
		kept_q.insert(pos, s);
	endfunction

	function automatic median_result_t close_set();
		median_result_t              r;
		int                          n;
		logic signed [MEDIAN_W:0]    sum;
		n = kept_q.size();
		if (n % 2 == 1) begin
			r.median = kept_q[n / 2];
		end else begin
			sum      = {kept_q[n/2-1][MEDIAN_W-1], kept_q[n/2-1]} +
			           {kept_q[n/2][MEDIAN_W-1], kept_q[n/2]};
			r.median = sum[MEDIAN_W:1];
		end
		r.count = n[SET_COUNT_W-1:0];
		r.ovf   = dropped;
		kept_q.delete();
		dropped = 1'b0;
		return r;
	endfunction

	always @(posedge clk) begin
		median_result_t exp_r;
		if (arst_n) begin
			if (result_valid) begin
				if (median_results_q.size() == 0) begin
					$display("%0t: result with no set pending: median %0d count %0d ovf %0b",
					         $time, median_value, set_count, overflow);
					fails++;
				end else begin
					exp_r = median_results_q.pop_front();
					if (median_value !== exp_r.median) begin
						$display("%0t: median_value expected %0d actual %0d",
						         $time, exp_r.median, median_value);
						fails++;
					end
					if (set_count !== exp_r.count) begin
						$display("%0t: set_count expected %0d actual %0d",
						         $time, exp_r.count, set_count);
						fails++;
					end
					if (overflow !== exp_r.ovf) begin
						$display("%0t: overflow expected %0b actual %0b",
						         $time, exp_r.ovf, overflow);
						fails++;
					end
				end
			end
			if (start && !busy) begin
				if (kept_q.size() < MAX_SAMPLES)
					keep_sample(sample);
				else
					dropped = 1'b1;
				if (last_sample)
					median_results_q.push_back(close_set());
			end
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the median unit testbench: clock, reset, sample stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mss_pkg::*;

	localparam sample_t S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam sample_t S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	sample_t                    sample;
	logic                       last_sample;
	logic                       result_valid;
	logic signed [MEDIAN_W-1:0] median_value;
	logic [SET_COUNT_W-1:0]     set_count;
	logic                       overflow;
	int                         fails;
	int                         pending;
	int                         items_sent;

	median_of_sample_set_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample       (sample),
		.last_sample  (last_sample),
		.result_valid (result_valid),
		.median_value (median_value),
		.set_count    (set_count),
		.overflow     (overflow)
	);

	median_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample       (sample),
		.last_sample  (last_sample),
		.result_valid (result_valid),
		.median_value (median_value),
		.set_count    (set_count),
		.overflow     (overflow),
		.fails        (fails),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic sample_t pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return sample_t'($urandom);
		else if (r < 8)
			return sample_t'($signed($urandom_range(0, 16)) - 8);
		else if (r == 8)
			return $urandom_range(0, 1) ? S_MAX : S_MIN;
		return sample_t'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
	endfunction

	task automatic send_item(input sample_t s, input logic l, input bit no_idle);
		int gap;
		start       <= 1'b1;
		sample      <= s;
		last_sample <= l;
		do @(posedge clk); while (busy);
		items_sent++;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_set(input sample_t vals[$], input bit no_idle);
		for (int i = 0; i < vals.size(); i++)
			send_item(vals[i], i == vals.size() - 1, no_idle);
	endtask

	initial begin
		sample_t vals[$];
		int      size;
		int      r;
		bit      no_idle;

		arst_n      = 1'b0;
		start       = 1'b0;
		sample      = '0;
		last_sample = 1'b0;
		items_sent  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_set('{S_MAX}, 1'b0);
		send_set('{S_MIN}, 1'b1);
		send_set('{S_MAX, S_MAX}, 1'b0);
		send_set('{S_MIN, S_MAX}, 1'b1);
		send_set('{S_MIN, S_MIN}, 1'b0);
		send_set('{-1, 0}, 1'b1);
		send_set('{-3, 0}, 1'b0);
		send_set('{3, 1, 2}, 1'b1);
		send_set('{5, 5, 2, 5}, 1'b0);
		vals.delete();
		for (int i = 0; i < MAX_SAMPLES + 2; i++)
			vals.push_back(sample_t'(MAX_SAMPLES - i));
		send_set(vals, 1'b1);

		while (items_sent < 400) begin
			r = $urandom_range(0, 19);
			if (r < 13)
				size = $urandom_range(1, 8);
			else if (r < 18)
				size = $urandom_range(9, 24);
			else
				size = $urandom_range(MAX_SAMPLES - 4, MAX_SAMPLES + 6);
			no_idle = ($urandom_range(0, 3) == 0);
			vals.delete();
			for (int i = 0; i < size; i++)
				vals.push_back(pick_sample());
			send_set(vals, no_idle);
		end

		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (MAX_SAMPLES) @(posedge clk);
		if (fails == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
